[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the pseudo-log block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/plr_pkg.sv]
`default_nettype none

package plr_pkg;

  localparam int IN_W          = 48;
  localparam int OUT_W         = 32;
  localparam int CFG_W         = 16;
  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 24;

  localparam logic [CFG_W-1:0] BASE_RESET = 16'd10;

  // Mantissas are Q1.30.
  localparam int MANT_W  = 31;
  localparam int K_W     = 6;
  localparam int SQ_N    = 32;
  localparam int M_W     = 33;
  localparam int LOG_N   = 30;
  localparam int LG_W    = 36;
  localparam int B_W     = 34;
  localparam int N_W     = LG_W + OUT_FRAC_BITS + 1;
  localparam int QW      = LG_W + OUT_FRAC_BITS - 29;
  localparam int REM_W   = B_W + 1;

  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  // Index of the highest set bit; zero for a zero word.
  function automatic logic [5:0] top_bit64(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[sv/plr_base_log.sv]
`default_nettype none

`include "assert_macros.svh"

module plr_base_log (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      we_i,
  input  wire logic [plr_pkg::CFG_W-1:0] base_i,
  output logic                           busy_o,
  output logic [plr_pkg::B_W-1:0]        b_o
);
  import plr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_NORM, ST_SQR} state_e;

  state_e             state_q;
  logic [CFG_W-1:0]   base_q;
  logic [MANT_W-1:0]  z_q;
  logic [29:0]        frac_q;
  logic [4:0]         cnt_q;
  logic [3:0]         p_q;
  logic [B_W-1:0]     b_q;

  logic [CFG_W-1:0]   base_eff;
  logic [5:0]         pb;
  logic [61:0]        sq;
  logic [31:0]        z2;
  logic [29:0]        frac_d;

  // A base below two is taken as two.
  assign base_eff = (base_q < 16'd2) ? 16'd2 : base_q;
  assign pb       = top_bit64(64'(base_eff));
  assign sq       = 62'(z_q) * 62'(z_q);
  assign z2       = sq[61:30];
  assign frac_d   = frac_q | (z2[31] ? (30'd1 << cnt_q) : 30'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NORM;
      base_q  <= BASE_RESET;
      z_q     <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      p_q     <= '0;
      b_q     <= '0;
    end else if (we_i) begin
      base_q  <= base_i;
      state_q <= ST_NORM;
    end else begin
      case (state_q)
        ST_NORM: begin
          z_q     <= 31'(64'(base_eff) << (6'd30 - pb));
          p_q     <= pb[3:0];
          frac_q  <= '0;
          cnt_q   <= 5'd29;
          state_q <= ST_SQR;
        end
        ST_SQR: begin
          z_q    <= z2[31] ? z2[31:1] : z2[30:0];
          frac_q <= frac_d;
          if (cnt_q == 5'd0) begin
            b_q     <= {p_q, frac_d};
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign b_o    = b_q;

  `PLR_ASSERT(plr_b_norm_bit, (state_q == ST_SQR && cnt_q == 5'd29) |-> z_q[30], "base mantissa not normalised")
  `PLR_ASSERT(plr_b_done, $fell(busy_o) |-> $past(cnt_q) == 5'd0, "base log finished early")

endmodule

`default_nettype wire

[sv/pseudo_log_rescale.sv]
// Pseudo-logarithm rescaler. Each input word carries a signed Q31.16 level x and
// produces one output word holding asinh(x/2)/ln(base) as signed Q7.24, rounded to
// nearest with halves away from zero and odd in x, so zero maps to zero. The base is
// written through cfg_we_i/cfg_log_base_i (reset 10; 0 and 1 act as 2). A write starts
// an evaluation of log2(base) by a single, reused squaring multiplier, during which
// in_ready_o is low; the same evaluation runs after reset. Otherwise, while it does not
// hold, the pipeline takes one word every cycle; from acceptance to out_valid_o a word passes
// through absolute value, normalisation, squaring, 32 square-root stages,
// normalisation of y+sqrt(y*y+1), 30 squaring stages for the binary logarithm, and 31
// restoring-division stages that divide by log2(base). The whole pipeline advances
// together; it holds only when its last stage and the output register are both full
// and the output word is not being taken.

`default_nettype none

`include "assert_macros.svh"

module pseudo_log_rescale (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [plr_pkg::CFG_W-1:0]        cfg_log_base_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [plr_pkg::IN_W-1:0]  level_in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [plr_pkg::OUT_W-1:0]      level_out_o
);
  import plr_pkg::*;

  // Stage map: 0 abs, 1 normalise, 2 square, then square root, sum, log2
  // normalise, squarings, numerator, division.
  localparam int SQ0  = 2;
  localparam int LG0  = SQ0 + SQ_N + 2;
  localparam int DV0  = LG0 + LOG_N + 1;
  localparam int NSTG = DV0 + QW + 1;

  localparam logic [IN_W-1:0] SMALL_LIM = IN_W'(64'd1 << (IN_FRAC_BITS + 1));

  // Base logarithm unit.
  logic            base_busy;
  logic [B_W-1:0]  b_val;

  plr_base_log u_base (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .base_i (cfg_log_base_i),
    .busy_o (base_busy),
    .b_o    (b_val)
  );

  // Flow control: one enable for every stage.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] neg_q;
  logic            out_valid_q;
  logic            pipe_en;
  logic            accept;
  logic            out_load;

  assign pipe_en    = !(vld_q[NSTG-1] && out_valid_q && !out_ready_i);
  assign in_ready_o = pipe_en && !base_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = pipe_en && vld_q[NSTG-1];

  // Stage 0: magnitude. The most negative level gives 2^47 exactly.
  logic [IN_W-1:0] raw;
  logic [IN_W-1:0] a_d;
  logic [IN_W-1:0] a_q;

  assign raw = level_in_i;
  assign a_d = raw[IN_W-1] ? (~raw + 48'd1) : raw;

  // Stage 1: scale |x|/2 to a Q1.30 mantissa m and an exponent k.
  logic [5:0]        pa;
  logic [63:0]       a64;
  logic [K_W-1:0]    k_d;
  logic [MANT_W-1:0] m_d;
  logic [K_W-1:0]    k_q;
  logic [MANT_W-1:0] m_q;

  always_comb begin
    a64 = 64'(a_q);
    pa  = top_bit64(a64);
    if (a_q < SMALL_LIM) begin
      k_d = '0;
      m_d = 31'(a64 << (29 - IN_FRAC_BITS));
    end else begin
      k_d = K_W'(7'(pa) - 7'(IN_FRAC_BITS + 1));
      if (pa >= 6'd30) begin
        m_d = 31'(a64 >> (pa - 6'd30));
      end else begin
        m_d = 31'(a64 << (6'd30 - pa));
      end
    end
  end

  // Stage 2 feeds the root: v = m*m + 2^(60-2k).
  logic [63:0] term;
  logic [63:0] v_d;

  always_comb begin
    term = (k_q <= 6'd30) ? (64'd1 << (7'd60 - 7'({k_q, 1'b0}))) : 64'd0;
    v_d  = 64'(62'(m_q) * 62'(m_q)) + term;
  end

  // Square root, one result bit per stage.
  logic [63:0]       sq_v_q [SQ_N+1];
  logic [63:0]       sq_r_q [SQ_N+1];
  logic [MANT_W-1:0] sq_m_q [SQ_N+1];
  logic [K_W-1:0]    sq_k_q [SQ_N+1];
  logic [63:0]       sq_v_d [SQ_N];
  logic [63:0]       sq_r_d [SQ_N];

  always_comb begin
    for (int j = 0; j < SQ_N; j++) begin
      logic [63:0] bitv;
      logic [63:0] rb;
      bitv = 64'd1 << (62 - 2 * j);
      rb   = sq_r_q[j] + bitv;
      if (sq_v_q[j] >= rb) begin
        sq_v_d[j] = sq_v_q[j] - rb;
        sq_r_d[j] = (sq_r_q[j] >> 1) + bitv;
      end else begin
        sq_v_d[j] = sq_v_q[j];
        sq_r_d[j] = sq_r_q[j] >> 1;
      end
    end
  end

  // M = m + sqrt(...).
  logic [M_W-1:0] mm_d;
  logic [M_W-1:0] mm_q;
  logic [K_W-1:0] mk_q;

  assign mm_d = 33'(sq_m_q[SQ_N]) + 33'(sq_r_q[SQ_N][31:0]);

  // Normalise M for the logarithm; integer part k + top bit - 30.
  logic [5:0]        pm;
  logic [MANT_W-1:0] z0_d;
  logic [5:0]        ip_d;

  always_comb begin
    pm = top_bit64(64'(mm_q));
    if (pm >= 6'd30) begin
      z0_d = 31'(64'(mm_q) >> (pm - 6'd30));
    end else begin
      z0_d = 31'(64'(mm_q) << (6'd30 - pm));
    end
    ip_d = 6'(7'(mk_q) + 7'(pm) - 7'd30);
  end

  // Fraction of log2, one bit per squaring stage.
  logic [MANT_W-1:0] lg_z_q [LOG_N+1];
  logic [29:0]       lg_f_q [LOG_N+1];
  logic [5:0]        lg_i_q [LOG_N+1];
  logic [MANT_W-1:0] lg_z_d [LOG_N];
  logic [29:0]       lg_f_d [LOG_N];

  always_comb begin
    for (int t = 0; t < LOG_N; t++) begin
      logic [61:0] sq;
      logic [31:0] z2;
      sq = 62'(lg_z_q[t]) * 62'(lg_z_q[t]);
      z2 = sq[61:30];
      if (z2[31]) begin
        lg_z_d[t] = z2[31:1];
        lg_f_d[t] = lg_f_q[t] | (30'd1 << (29 - t));
      end else begin
        lg_z_d[t] = z2[30:0];
        lg_f_d[t] = lg_f_q[t];
      end
    end
  end

  // Numerator LG*2^OUT_FRAC_BITS + B/2; the remainder starts with its top bits.
  logic [LG_W-1:0] lg_val;
  logic [N_W-1:0]  n_d;

  assign lg_val = {lg_i_q[LOG_N], lg_f_q[LOG_N]};
  assign n_d    = (N_W'(lg_val) << OUT_FRAC_BITS) + N_W'(b_val >> 1);

  // Restoring division by B, one quotient bit per stage.
  logic [N_W-1:0]   dv_n_q [QW+1];
  logic [REM_W-1:0] dv_r_q [QW+1];
  logic [QW-1:0]    dv_q_q [QW+1];
  logic [REM_W-1:0] dv_r_d [QW];
  logic [QW-1:0]    dv_q_d [QW];

  always_comb begin
    for (int t = 0; t < QW; t++) begin
      logic [REM_W-1:0] trial;
      logic             ge;
      trial = {dv_r_q[t][REM_W-2:0], dv_n_q[t][QW-1-t]};
      ge    = (trial >= REM_W'(b_val));
      dv_r_d[t] = ge ? (trial - REM_W'(b_val)) : trial;
      dv_q_d[t] = {dv_q_q[t][QW-2:0], ge};
    end
  end

  // Saturate the magnitude and apply the sign.
  logic [30:0]      mag;
  logic [OUT_W-1:0] res_d;
  logic [OUT_W-1:0] res_q;

  always_comb begin
    if (64'(dv_q_q[QW]) > 64'(MAG_MAX)) begin
      mag = MAG_MAX;
    end else begin
      mag = 31'(dv_q_q[QW]);
    end
    res_d = neg_q[NSTG-1] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
  end

  // Valid bits and signs travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pipe_en) begin
        vld_q <= {vld_q[NSTG-2:0], accept};
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Data path; no reset needed.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      neg_q <= {neg_q[NSTG-2:0], raw[IN_W-1]};
      a_q   <= a_d;
      k_q   <= k_d;
      m_q   <= m_d;
      sq_v_q[0] <= v_d;
      sq_r_q[0] <= '0;
      sq_m_q[0] <= m_q;
      sq_k_q[0] <= k_q;
      for (int j = 0; j < SQ_N; j++) begin
        sq_v_q[j+1] <= sq_v_d[j];
        sq_r_q[j+1] <= sq_r_d[j];
        sq_m_q[j+1] <= sq_m_q[j];
        sq_k_q[j+1] <= sq_k_q[j];
      end
      mm_q <= mm_d;
      mk_q <= sq_k_q[SQ_N];
      lg_z_q[0] <= z0_d;
      lg_f_q[0] <= '0;
      lg_i_q[0] <= ip_d;
      for (int t = 0; t < LOG_N; t++) begin
        lg_z_q[t+1] <= lg_z_d[t];
        lg_f_q[t+1] <= lg_f_d[t];
        lg_i_q[t+1] <= lg_i_q[t];
      end
      dv_n_q[0] <= n_d;
      dv_r_q[0] <= REM_W'(n_d >> QW);
      dv_q_q[0] <= '0;
      for (int t = 0; t < QW; t++) begin
        dv_n_q[t+1] <= dv_n_q[t];
        dv_r_q[t+1] <= dv_r_d[t];
        dv_q_q[t+1] <= dv_q_d[t];
      end
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_out_o = res_q;

  `PLR_ASSERT(plr_busy_blocks, base_busy |-> !in_ready_o, "word taken while base log is busy")
  `PLR_ASSERT(plr_out_from_pipe, $rose(out_valid_q) |-> $past(vld_q[NSTG-1]), "output without a word")
  `PLR_ASSERT(plr_stall_holds, !pipe_en |=> $stable(vld_q), "pipeline moved while stalled")
  `PLR_ASSERT_ALWAYS(plr_reset_empty, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

`default_nettype wire
